[rtl/multi_timer_with_reminder_macros.svh]
// Assertion macros for the multi timer block checker.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef MULTI_TIMER_WITH_REMINDER_MACROS_SVH
`define MULTI_TIMER_WITH_REMINDER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MTR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mtr_pkg.sv]
// Shared types and constants for the multi timer block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtr_pkg;

    localparam int MTR_TIMERS      = 16;
    localparam int MTR_TIME_BITS   = 32;
    localparam int MTR_MAX_RESULTS = 32;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_CANCEL  = 3'd2,
        CMD_SUSPEND = 3'd3,
        CMD_RESUME  = 3'd4,
        CMD_STATUS  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_SUSP = 2'd1,
        ST_CANC = 2'd2,
        ST_EXP  = 2'd3
    } run_t;

    typedef enum logic [1:0] {
        KIND_RESP   = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_REMIND = 2'd2
    } kind_t;

    localparam logic [1:0] MODE_GENERIC = 2'd0;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // One result word as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic        ok;
        logic [3:0]  id;
        run_t        run;
        logic [1:0]  mode;
        logic [31:0] left;
        logic [31:0] rpt;
        logic [31:0] lead;
        logic        last;
    } result_t;

    // Up to three result words produced by one entry update, in order.
    typedef struct packed {
        logic [2:0]        valid;
        result_t [2:0]     item;
    } ev_set_t;

endpackage

`default_nettype wire

[rtl/mtr_mem.sv]
// Timer entry storage: one write port, one registered read port.
// Depends on mtr_pkg for default sizes.
`default_nettype none

module mtr_mem
    import mtr_pkg::*;
#(
    parameter int DEPTH = MTR_TIMERS,
    parameter int AW    = $clog2(MTR_TIMERS),
    parameter int WIDTH = 4 * MTR_TIME_BITS + 5
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/mtr_eval.sv]
// Entry update logic: applies one command or one tick to a timer entry.
// Depends on mtr_pkg for command, state and result types.
`default_nettype none

module mtr_eval
    import mtr_pkg::*;
#(
    parameter int SW = MTR_TIME_BITS
) (
    input  wire cmd_t              cmd,
    input  wire logic              hit,
    input  wire logic [3:0]        id_out,
    input  wire logic [31:0]       interval_ticks,
    input  wire logic [31:0]       repeat_ticks,
    input  wire logic [31:0]       lead_ticks,
    input  wire logic [1:0]        mode_in,
    input  wire logic [4*SW+4:0]   entry_in,
    output logic      [4*SW+4:0]   entry_out,
    output logic                   wr_en,
    output ev_set_t                evs
);

    typedef struct packed {
        logic [SW-1:0] remaining;
        logic [SW-1:0] cur;
        logic [SW-1:0] rpt;
        logic [SW-1:0] lead;
        logic [1:0]    mode;
        run_t          run;
        logic          reminded;
    } entry_t;

    function automatic result_t mk(kind_t k, logic okv, run_t st, logic [SW-1:0] left,
                                   entry_t ent, logic [3:0] idv);
        result_t r;
        r.kind = k;
        r.ok   = okv;
        r.id   = idv;
        r.run  = st;
        r.mode = ent.mode;
        r.left = 32'(left);
        r.rpt  = 32'(ent.rpt);
        r.lead = 32'(ent.lead);
        r.last = 1'b0;
        return r;
    endfunction

    entry_t        e;
    entry_t        n;
    logic [SW-1:0] dec;
    logic [SW-1:0] ivl;
    logic          lead_ok;
    logic          ok_r;
    result_t       zero_resp;

    always_comb
    begin
        e       = entry_t'(entry_in);
        n       = e;
        evs     = '0;
        wr_en   = 1'b0;
        ok_r    = 1'b0;
        ivl     = interval_ticks[SW-1:0];
        dec     = (e.remaining == '0) ? '0 : e.remaining - SW'(1);
        lead_ok = e.lead > SW'(1);

        zero_resp      = '0;
        zero_resp.kind = KIND_RESP;
        zero_resp.id   = id_out;

        unique case (cmd)
            CMD_TICK:
            begin
                if (e.run == ST_RUN)
                begin
                    wr_en       = 1'b1;
                    n.remaining = dec;
                    if (!e.reminded && lead_ok && dec <= e.lead)
                    begin
                        n.reminded       = 1'b1;
                        evs.valid[0]     = 1'b1;
                        evs.item[0]      = mk(KIND_REMIND, 1'b1, ST_RUN, dec, e, id_out);
                    end
                    if (dec == '0)
                    begin
                        evs.valid[1] = 1'b1;
                        if (e.rpt != '0)
                        begin
                            // reload, then look at the reminder again
                            n.cur        = e.rpt;
                            n.remaining  = e.rpt;
                            n.reminded   = 1'b0;
                            evs.item[1]  = mk(KIND_EXPIRY, 1'b1, ST_RUN, '0, e, id_out);
                            if (lead_ok && e.rpt <= e.lead)
                            begin
                                n.reminded   = 1'b1;
                                evs.valid[2] = 1'b1;
                                evs.item[2]  = mk(KIND_REMIND, 1'b1, ST_RUN, e.rpt, e, id_out);
                            end
                        end
                        else
                        begin
                            n.run       = ST_EXP;
                            evs.item[1] = mk(KIND_EXPIRY, 1'b1, ST_EXP, '0, e, id_out);
                        end
                    end
                end
            end
            CMD_START:
            begin
                if (hit)
                begin
                    wr_en       = 1'b1;
                    ok_r        = 1'b1;
                    n.remaining = ivl;
                    n.cur       = ivl;
                    n.rpt       = repeat_ticks[SW-1:0];
                    n.lead      = lead_ticks[SW-1:0];
                    n.mode      = (mode_in == MODE_UNKNOWN) ? MODE_GENERIC : mode_in;
                    n.run       = ST_RUN;
                    n.reminded  = 1'b0;
                    if (lead_ticks[SW-1:0] > SW'(1) && ivl <= lead_ticks[SW-1:0])
                    begin
                        n.reminded   = 1'b1;
                        evs.valid[0] = 1'b1;
                        evs.item[0]  = mk(KIND_REMIND, 1'b1, ST_RUN, ivl, n, id_out);
                    end
                end
            end
            CMD_CANCEL:
            begin
                if (hit && e.run != ST_CANC)
                begin
                    wr_en = 1'b1;
                    ok_r  = (e.run == ST_RUN);
                    n.run = ST_CANC;
                end
            end
            CMD_SUSPEND:
            begin
                if (hit && e.run == ST_RUN)
                begin
                    wr_en = 1'b1;
                    ok_r  = 1'b1;
                    n.run = ST_SUSP;
                end
            end
            CMD_RESUME:
            begin
                if (hit && e.run == ST_SUSP)
                begin
                    wr_en       = 1'b1;
                    ok_r        = 1'b1;
                    n.run       = ST_RUN;
                    n.remaining = e.cur;
                    n.reminded  = 1'b0;
                    if (lead_ok && e.cur <= e.lead)
                    begin
                        n.reminded   = 1'b1;
                        evs.valid[0] = 1'b1;
                        evs.item[0]  = mk(KIND_REMIND, 1'b1, ST_RUN, e.cur, n, id_out);
                    end
                end
            end
            CMD_STATUS:
            begin
                ok_r = 1'b1;
            end
            default:
            begin
                ok_r = 1'b0;
            end
        endcase

        // every command ends with its response word
        if (cmd != CMD_TICK)
        begin
            evs.valid[1] = 1'b1;
            evs.item[1]  = hit ? mk(KIND_RESP, ok_r, n.run, n.remaining, n, id_out)
                               : zero_resp;
        end

        entry_out = n;
    end

endmodule

`default_nettype wire

[rtl/mtr_out.sv]
// Result packer: holds one word back to mark the final one, caps the count
// per command and drives the output register. Depends on mtr_pkg.
`default_nettype none

module mtr_out
    import mtr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  wire result_t push_item,
    output logic         push_ready,
    input  wire logic    flush,
    output logic         flush_done,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_item
);

    localparam int CNTW = $clog2(MTR_MAX_RESULTS + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            pend_valid_reg, pend_valid_next;
    result_t         pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;
    logic            out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        push_ready      = 1'b0;
        flush_done      = 1'b0;

        if (push_valid)
        begin
            priority if (cnt_reg == CNTW'(MTR_MAX_RESULTS))
            begin
                // drop words beyond the cap
                push_ready = 1'b1;
            end
            else if (!pend_valid_reg)
            begin
                pend_next       = push_item;
                pend_valid_next = 1'b1;
                cnt_next        = cnt_reg + CNTW'(1);
                push_ready      = 1'b1;
            end
            else if (out_free)
            begin
                out_next        = pend_reg;
                out_next.last   = 1'b0;
                out_valid_next  = 1'b1;
                pend_next       = push_item;
                cnt_next        = cnt_reg + CNTW'(1);
                push_ready      = 1'b1;
            end
            else
            begin
                // hold the word until the output register frees
                push_ready = 1'b0;
            end
        end
        else if (flush)
        begin
            priority if (!pend_valid_reg)
            begin
                flush_done = 1'b1;
                cnt_next   = '0;
            end
            else if (out_free)
            begin
                out_next        = pend_reg;
                out_next.last   = 1'b1;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
                flush_done      = 1'b1;
                cnt_next        = '0;
            end
            else
            begin
                // hold the final word until the output register frees
                flush_done = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

[rtl/multi_timer_with_reminder.sv]
// Top level of the multi timer block: command sequencer around the entry memory.
// Depends on mtr_pkg, mtr_mem, mtr_eval and mtr_out.
//
// A table of up to TIMERS countdown timers in millisecond ticks. Each input word
// is one command: tick, start, cancel, suspend, resume or status. Start takes the
// next free slot; the other commands address a slot by timer_id. Every command
// gives one response word; a tick gives only expiry and reminder words, in timer
// index order, possibly none. The final word of a command carries last. At most
// 32 words leave per command; the rest are dropped. The block works on one
// command at a time: a command on an existing timer reads its entry and writes
// back any change, a start writes the next free slot, and a tick visits every
// allocated timer; each extra result word and any output stall hold the sequence.
// Ticks and commands on existing timers read-modify-write the single entry memory,
// one entry per pass, through a registered read port; a start only writes. No
// clearing pass is needed after reset: only slots below the fill count are ever
// read. in_ready is high only between commands.
`default_nettype none

module multi_timer_with_reminder
    import mtr_pkg::*;
#(
    parameter int TIMERS    = MTR_TIMERS,
    parameter int TIME_BITS = MTR_TIME_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [3:0]  timer_id,
    input  wire logic [31:0] interval_ticks,
    input  wire logic [31:0] repeat_ticks,
    input  wire logic [31:0] lead_ticks,
    input  wire logic [1:0]  mode_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic             ok,
    output logic [3:0]       timer_out,
    output logic [1:0]       state_code,
    output logic [1:0]       mode_out,
    output logic [31:0]      time_left,
    output logic [31:0]      repeat_out,
    output logic [31:0]      lead_out,
    output logic             last
);

    // Stored times never exceed the 32-bit input width.
    localparam int SW = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int EW = 4 * SW + 5;
    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int HW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_EMIT,
        S_DONE
    } seq_state_t;

    seq_state_t      state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   slots_reg, slots_next;
    cmd_t            cmd_reg, cmd_next;
    logic [3:0]      id_reg, id_next;
    logic            hit_reg, hit_next;
    logic [31:0]     ivl_reg, ivl_next;
    logic [31:0]     rpt_reg, rpt_next;
    logic [31:0]     lead_reg, lead_next;
    logic [1:0]      mode_reg, mode_next;
    ev_set_t         evs_reg, evs_next;

    logic [EW-1:0]   rd_data;
    logic [EW-1:0]   upd_entry;
    logic            upd_we;
    ev_set_t         upd_evs;
    logic [3:0]      eval_id;
    logic            mem_we;
    logic            mem_re;

    logic            push_valid;
    result_t         push_item;
    logic            push_ready;
    logic            flush;
    logic            flush_done;
    result_t         out_item;

    // Events and start responses carry the slot index; others echo the id.
    assign eval_id = (cmd_reg == CMD_TICK || (cmd_reg == CMD_START && hit_reg))
                     ? 4'(idx_reg) : id_reg;

    // Sequencer: one entry is read (not for a start), updated and written back per pass.
    // Commands are serialized, so a write and a later read of the same entry never overlap.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        slots_next = slots_reg;
        cmd_next   = cmd_reg;
        id_next    = id_reg;
        hit_next   = hit_reg;
        ivl_next   = ivl_reg;
        rpt_next   = rpt_reg;
        lead_next  = lead_reg;
        mode_next  = mode_reg;
        evs_next   = evs_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        push_valid = 1'b0;
        push_item  = evs_reg.item[0];
        flush      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next  = cmd_t'(cmd);
                    ivl_next  = interval_ticks;
                    rpt_next  = repeat_ticks;
                    lead_next = lead_ticks;
                    mode_next = mode_in;
                    id_next   = timer_id;
                    unique case (cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            hit_next   = 1'b1;
                            idx_next   = '0;
                            state_next = (slots_reg == '0) ? S_DONE : S_READ;
                        end
                        CMD_START:
                        begin
                            // a start on a full table answers with id zero
                            hit_next   = slots_reg < CW'(TIMERS);
                            idx_next   = IW'(slots_reg);
                            id_next    = 4'd0;
                            state_next = S_EVAL;
                        end
                        CMD_CANCEL, CMD_SUSPEND, CMD_RESUME, CMD_STATUS:
                        begin
                            hit_next   = HW'(timer_id) < HW'(slots_reg);
                            idx_next   = IW'(timer_id);
                            state_next = (HW'(timer_id) < HW'(slots_reg)) ? S_READ : S_EVAL;
                        end
                        default:
                        begin
                            hit_next   = 1'b0;
                            state_next = S_EVAL;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // write back the updated entry and hold its result words
                mem_we   = upd_we;
                evs_next = upd_evs;
                if (cmd_reg == CMD_START && hit_reg)
                begin
                    slots_next = slots_reg + CW'(1);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                priority if (evs_reg.valid[0])
                begin
                    push_valid = 1'b1;
                    push_item  = evs_reg.item[0];
                    if (push_ready)
                    begin
                        evs_next.valid[0] = 1'b0;
                    end
                end
                else if (evs_reg.valid[1])
                begin
                    push_valid = 1'b1;
                    push_item  = evs_reg.item[1];
                    if (push_ready)
                    begin
                        evs_next.valid[1] = 1'b0;
                    end
                end
                else if (evs_reg.valid[2])
                begin
                    push_valid = 1'b1;
                    push_item  = evs_reg.item[2];
                    if (push_ready)
                    begin
                        evs_next.valid[2] = 1'b0;
                    end
                end
                else if (cmd_reg == CMD_TICK && (CW'(idx_reg) + CW'(1)) != slots_reg)
                begin
                    // advance the scan to the next allocated timer
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // release the held word with last set
                flush = 1'b1;
                if (flush_done)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            slots_reg <= '0;
            cmd_reg   <= CMD_TICK;
            id_reg    <= '0;
            hit_reg   <= 1'b0;
            ivl_reg   <= '0;
            rpt_reg   <= '0;
            lead_reg  <= '0;
            mode_reg  <= '0;
            evs_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slots_reg <= slots_next;
            cmd_reg   <= cmd_next;
            id_reg    <= id_next;
            hit_reg   <= hit_next;
            ivl_reg   <= ivl_next;
            rpt_reg   <= rpt_next;
            lead_reg  <= lead_next;
            mode_reg  <= mode_next;
            evs_reg   <= evs_next;
        end
    end

    mtr_mem #(
        .DEPTH (TIMERS),
        .AW    (IW),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_data (upd_entry),
        .rd_en   (mem_re),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    mtr_eval #(
        .SW (SW)
    ) u_eval (
        .cmd            (cmd_reg),
        .hit            (hit_reg),
        .id_out         (eval_id),
        .interval_ticks (ivl_reg),
        .repeat_ticks   (rpt_reg),
        .lead_ticks     (lead_reg),
        .mode_in        (mode_reg),
        .entry_in       (rd_data),
        .entry_out      (upd_entry),
        .wr_en          (upd_we),
        .evs            (upd_evs)
    );

    mtr_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .flush      (flush),
        .flush_done (flush_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    assign kind       = out_item.kind;
    assign ok         = out_item.ok;
    assign timer_out  = out_item.id;
    assign state_code = out_item.run;
    assign mode_out   = out_item.mode;
    assign time_left  = out_item.left;
    assign repeat_out = out_item.rpt;
    assign lead_out   = out_item.lead;
    assign last       = out_item.last;

endmodule

`default_nettype wire

[rtl/mtr_checker.sv]
// Port-level checks for the multi timer block, bound to its top level.
// Depends on mtr_pkg and the block's assertion macro header.
`default_nettype none

`include "multi_timer_with_reminder_macros.svh"

module mtr_checker
    import mtr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic        ok,
    input wire logic [3:0]  timer_out,
    input wire logic [31:0] time_left,
    input wire logic        last
);

    // a stalled word holds
    `MTR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(ok) && $stable(timer_out) && $stable(time_left) && $stable(last), "stalled output word changed")

    // a command finishes with its response, so a response is always final
    `MTR_ASSERT_IMP(a_resp_last, out_valid && kind == KIND_RESP, last, "response word without last")

    // events always report success
    `MTR_ASSERT_IMP(a_event_ok, out_valid && kind != KIND_RESP, ok, "event word with ok low")

    // an expiry reports no time left
    `MTR_ASSERT_IMP(a_expiry_zero, out_valid && kind == KIND_EXPIRY, time_left == 32'd0, "expiry with time left")

    // one command at a time: ready drops right after a word is taken
    `MTR_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind multi_timer_with_reminder mtr_checker u_mtr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .ok        (ok),
    .timer_out (timer_out),
    .time_left (time_left),
    .last      (last)
);

`default_nettype wire

[dv/mtr_checker.sv]
// Checker for the multi timer block: watches both channels, predicts every result word
// from the accepted command words, and compares them in order.
// Depends on mtr_pkg for the command, state and kind codes and the result word layout.
`timescale 1ns / 1ps

module mtr_tb_checker
    import mtr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [3:0]  timer_id,
    input  wire logic [31:0] interval_ticks,
    input  wire logic [31:0] repeat_ticks,
    input  wire logic [31:0] lead_ticks,
    input  wire logic [1:0]  mode_in,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  kind,
    input  wire logic        ok,
    input  wire logic [3:0]  timer_out,
    input  wire logic [1:0]  state_code,
    input  wire logic [1:0]  mode_out,
    input  wire logic [31:0] time_left,
    input  wire logic [31:0] repeat_out,
    input  wire logic [31:0] lead_out,
    input  wire logic        last,
    output int               mismatches,
    output int               outstanding
);

    // Shadow timer table
    logic [4:0]  slots_used;
    logic [31:0] left_q   [MTR_TIMERS];
    logic [31:0] period_q [MTR_TIMERS];
    logic [31:0] rpt_q    [MTR_TIMERS];
    logic [31:0] lead_q   [MTR_TIMERS];
    logic [1:0]  mode_q   [MTR_TIMERS];
    run_t        run_q    [MTR_TIMERS];
    logic        reminded_q [MTR_TIMERS];

    result_t expected_words[$];
    int      words_now;

    task automatic push_word(input kind_t k, input logic good, input logic [3:0] id,
                             input run_t st, input logic [1:0] md, input logic [31:0] tl,
                             input logic [31:0] rp, input logic [31:0] ld);
        result_t w;
        if (words_now < MTR_MAX_RESULTS)
        begin
            w.kind = k;
            w.ok   = good;
            w.id   = id;
            w.run  = st;
            w.mode = md;
            w.left = tl;
            w.rpt  = rp;
            w.lead = ld;
            w.last = 1'b0;
            expected_words.insert(expected_words.size(), w);
            words_now++;
        end
    endtask

    task automatic push_slot(input kind_t k, input logic good, input int i,
                             input logic [31:0] tl);
        push_word(k, good, 4'(i), run_q[i], mode_q[i], tl, rpt_q[i], lead_q[i]);
    endtask

    task automatic note_reminder(input int i);
        if (run_q[i] == ST_RUN && !reminded_q[i] && lead_q[i] > 32'd1 &&
            left_q[i] <= lead_q[i])
        begin
            push_slot(KIND_REMIND, 1'b1, i, left_q[i]);
            reminded_q[i] = 1'b1;
        end
    endtask

    task automatic predict_timer_words(input logic [2:0] c, input logic [3:0] id,
                                       input logic [31:0] iv, input logic [31:0] rp,
                                       input logic [31:0] ld, input logic [1:0] md);
        int      s;
        logic    good;
        result_t w;
        words_now = 0;
        good = 1'b0;
        case (c)
            CMD_TICK:
            begin
                for (int i = 0; i < slots_used; i++)
                begin
                    if (run_q[i] != ST_RUN)
                        continue;
                    if (left_q[i] != 32'd0)
                        left_q[i]--;
                    note_reminder(i);
                    if (left_q[i] == 32'd0)
                    begin
                        if (rpt_q[i] != 32'd0)
                        begin
                            period_q[i]   = rpt_q[i];
                            left_q[i]     = rpt_q[i];
                            reminded_q[i] = 1'b0;
                            push_slot(KIND_EXPIRY, 1'b1, i, 32'd0);
                            note_reminder(i);
                        end
                        else
                        begin
                            run_q[i] = ST_EXP;
                            push_slot(KIND_EXPIRY, 1'b1, i, 32'd0);
                        end
                    end
                end
            end
            CMD_START:
            begin
                if (slots_used < MTR_TIMERS)
                begin
                    s = slots_used;
                    left_q[s]     = iv;
                    period_q[s]   = iv;
                    rpt_q[s]      = rp;
                    lead_q[s]     = ld;
                    mode_q[s]     = (md == MODE_UNKNOWN) ? MODE_GENERIC : md;
                    run_q[s]      = ST_RUN;
                    reminded_q[s] = 1'b0;
                    slots_used++;
                    note_reminder(s);
                    push_slot(KIND_RESP, 1'b1, s, left_q[s]);
                end
                else
                    push_word(KIND_RESP, 1'b0, 4'd0, ST_RUN, 2'd0, 32'd0, 32'd0, 32'd0);
            end
            CMD_CANCEL, CMD_SUSPEND, CMD_RESUME, CMD_STATUS:
            begin
                if (id >= slots_used)
                    push_word(KIND_RESP, 1'b0, id, ST_RUN, 2'd0, 32'd0, 32'd0, 32'd0);
                else
                begin
                    if (c == CMD_CANCEL)
                    begin
                        if (run_q[id] != ST_CANC)
                        begin
                            good = (run_q[id] == ST_RUN);
                            run_q[id] = ST_CANC;
                        end
                    end
                    else if (c == CMD_SUSPEND)
                    begin
                        if (run_q[id] == ST_RUN)
                        begin
                            run_q[id] = ST_SUSP;
                            good = 1'b1;
                        end
                    end
                    else if (c == CMD_RESUME)
                    begin
                        // restart the full current interval
                        if (run_q[id] == ST_SUSP)
                        begin
                            run_q[id]      = ST_RUN;
                            left_q[id]     = period_q[id];
                            reminded_q[id] = 1'b0;
                            good = 1'b1;
                            note_reminder(int'(id));
                        end
                    end
                    else
                        good = 1'b1;
                    push_slot(KIND_RESP, good, int'(id), left_q[id]);
                end
            end
            default:
                push_word(KIND_RESP, 1'b0, id, ST_RUN, 2'd0, 32'd0, 32'd0, 32'd0);
        endcase
        if (words_now > 0)
        begin
            w = expected_words[expected_words.size() - 1];
            w.last = 1'b1;
            expected_words[expected_words.size() - 1] = w;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            slots_used = 5'd0;
            expected_words.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_timer_words(cmd, timer_id, interval_ticks, repeat_ticks,
                                    lead_ticks, mode_in);
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: kind %0d timer %0d", kind, timer_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("ok", 32'(want.ok), 32'(ok));
                    check_field("timer_out", 32'(want.id), 32'(timer_out));
                    check_field("state_code", 32'(want.run), 32'(state_code));
                    check_field("mode_out", 32'(want.mode), 32'(mode_out));
                    check_field("time_left", want.left, time_left);
                    check_field("repeat_out", want.rpt, repeat_out);
                    check_field("lead_out", want.lead, lead_out);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

[dv/tb_multi_timer_with_reminder.sv]
// Top of the multi timer testbench: clock, reset, command stimulus, output stalls, verdict.
// Depends on mtr_pkg, the multi_timer_with_reminder block and the mtr_tb_checker module.
`timescale 1ns / 1ps

module tb_multi_timer_with_reminder;
    import mtr_pkg::*;

    // Command codes the block treats as unused
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 435;
    // Quiet cycles after the block has gone idle, to catch any stray result word
    localparam int DRAIN_CYCLES   = 150;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [3:0]  timer_id;
    logic [31:0] interval_ticks;
    logic [31:0] repeat_ticks;
    logic [31:0] lead_ticks;
    logic [1:0]  mode_in;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic        ok;
    logic [3:0]  timer_out;
    logic [1:0]  state_code;
    logic [1:0]  mode_out;
    logic [31:0] time_left;
    logic [31:0] repeat_out;
    logic [31:0] lead_out;
    logic        last;

    int   mismatches;
    int   outstanding;
    int   started;   // start words sent, capped at the table size
    logic calm;      // suppress idling on both sides during the quiet stretch

    multi_timer_with_reminder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .timer_id       (timer_id),
        .interval_ticks (interval_ticks),
        .repeat_ticks   (repeat_ticks),
        .lead_ticks     (lead_ticks),
        .mode_in        (mode_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .ok             (ok),
        .timer_out      (timer_out),
        .state_code     (state_code),
        .mode_out       (mode_out),
        .time_left      (time_left),
        .repeat_out     (repeat_out),
        .lead_out       (lead_out),
        .last           (last)
    );

    mtr_tb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .timer_id       (timer_id),
        .interval_ticks (interval_ticks),
        .repeat_ticks   (repeat_ticks),
        .lead_ticks     (lead_ticks),
        .mode_in        (mode_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .ok             (ok),
        .timer_out      (timer_out),
        .state_code     (state_code),
        .mode_out       (mode_out),
        .time_left      (time_left),
        .repeat_out     (repeat_out),
        .lead_out       (lead_out),
        .last           (last),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: drop ready at random with a chance of 36 in 100, except in the quiet stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    // Present one command word and hold it until the block takes it. Idle first at
    // random; valid is lowered only on idle cycles, never in the step that raises it.
    task automatic send_word(input logic [2:0] c, input logic [3:0] id,
                             input logic [31:0] iv, input logic [31:0] rp,
                             input logic [31:0] ld, input logic [1:0] md);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        cmd            <= c;
        timer_id       <= id;
        interval_ticks <= iv;
        repeat_ticks   <= rp;
        lead_ticks     <= ld;
        mode_in        <= md;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c == CMD_START && started < MTR_TIMERS)
            started++;
    endtask

    initial
    begin : stimulus
        int          r;
        logic [2:0]  c;
        logic [3:0]  id;
        logic [31:0] iv;
        logic [31:0] rp;
        logic [31:0] ld;
        logic [1:0]  md;

        // Hold every input at a known value and assert reset
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_TICK;
        timer_id       = 4'd0;
        interval_ticks = 32'd0;
        repeat_ticks   = 32'd0;
        lead_ticks     = 32'd0;
        mode_in        = MODE_GENERIC;
        calm           = 1'b0;
        started        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. Commands on an empty table all address bad ids.
        send_word(CMD_STATUS, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_CANCEL, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        send_word(CMD_SPARE_LO, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_SPARE_HI, 4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        // Zero interval one-shot: expires on the first tick
        send_word(CMD_START, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0);
        // Repeating timer whose reload lands inside its own lead: reminder right after expiry
        send_word(CMD_START, 4'd0, 32'd5, 32'd3, 32'd4, 2'd1);
        // Lead already covers the interval: reminder ahead of the response; unknown mode
        send_word(CMD_START, 4'd0, 32'd2, 32'd0, 32'hFFFF_FFFF, 2'd3);
        // Longest times, and a lead of one tick that never reminds
        send_word(CMD_START, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 2'd2);
        send_word(CMD_SUSPEND, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_SUSPEND, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_RESUME, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_RESUME, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_CANCEL, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_CANCEL, 4'd3, 32'd0, 32'd0, 32'd0, 2'd0);
        // Resume with the lead covering the interval: reminder ahead of the response
        send_word(CMD_SUSPEND, 4'd2, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_RESUME, 4'd2, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_SUSPEND, 4'd2, 32'd0, 32'd0, 32'd0, 2'd0);
        // Cancel of a suspended and of an expired timer: both refused but applied
        send_word(CMD_CANCEL, 4'd2, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_CANCEL, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_STATUS, 4'd1, 32'd0, 32'd0, 32'd0, 2'd0);
        repeat (DIRECTED_WORDS - 22)
            send_word(CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 2'd0);
        send_word(CMD_STATUS, 4'd15, 32'd0, 32'd0, 32'd0, 2'd0);

        // Random words: mostly ticks and commands on live timers with short intervals,
        // so that timers expire, reload, remind and get suspended and resumed in the run
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm <= (n >= 180 && n < 290);
            r  = $urandom_range(0, 99);
            iv = $urandom();
            rp = $urandom();
            ld = $urandom();
            md = 2'($urandom_range(0, 3));
            if (started > 0 && $urandom_range(0, 99) < 80)
                id = 4'($urandom_range(0, started - 1));
            else
                id = 4'($urandom_range(0, 15));
            if (r < 46)
                c = CMD_TICK;
            else if (r < 58)
                c = CMD_START;
            else if (r < 66)
                c = CMD_CANCEL;
            else if (r < 75)
                c = CMD_SUSPEND;
            else if (r < 85)
                c = CMD_RESUME;
            else if (r < 96)
                c = CMD_STATUS;
            else
                c = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;

            // Shape start fields: short intervals, a mix of one-shot and repeat
            if (c == CMD_START)
            begin
                if ($urandom_range(0, 99) < 85)
                    iv = $urandom_range(0, 24);
                r = $urandom_range(0, 99);
                if (r < 40)
                    rp = 32'd0;
                else if (r < 85)
                    rp = $urandom_range(1, 16);
                r = $urandom_range(0, 99);
                if (r < 30)
                    ld = $urandom_range(0, 1);
                else if (r < 80)
                    ld = $urandom_range(2, 12);
            end
            send_word(c, id, iv, rp, ld, md);
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        // Drain: wait until the last command is done and every expected word is seen
        @(posedge clk);
        while (outstanding != 0 || !in_ready)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
